@@ rtl/pla_pkg.sv @@
// ----------------------------------------------------------------------------
// pla_pkg
// Shared types and constants of the piecewise linear arccos unit.
// ----------------------------------------------------------------------------
package pla_pkg;

  localparam int WORD_W  = 32;
  localparam int ANGLE_W = 24;
  localparam int SEG_W   = 5;
  localparam int IDX_W   = 5;
  localparam int PROD_W  = 49;
  localparam int ACC_W   = 34;
  localparam int FIN_W   = 35;

  localparam logic signed [ACC_W-1:0] PI_Q20    = 34'sd3294199;
  localparam logic signed [FIN_W-1:0] ANGLE_MAX = 35'sd8388607;
  localparam logic signed [FIN_W-1:0] ANGLE_MIN = -35'sd8388608;

  typedef enum logic {
    CMD_COMPUTE = 1'b0,
    CMD_WRITE   = 1'b1
  } pla_cmd_t;

  typedef struct packed {
    pla_cmd_t                  cmd;
    logic                      neg;
    logic [WORD_W-1:0]         mag;
    logic [SEG_W-1:0]          seg;
    logic                      wr_ok;
    logic [IDX_W-1:0]          idx;
    logic signed [WORD_W-1:0]  slope;
    logic signed [WORD_W-1:0]  icpt;
  } pla_item_t;

endpackage

@@ rtl/pla_in_if.sv @@
// ----------------------------------------------------------------------------
// pla_in_if
// Input channel: command words with a cosine or one table entry.
// ----------------------------------------------------------------------------
interface pla_in_if import pla_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [WORD_W-1:0] cos_value;
  logic [IDX_W-1:0]         entry_index;
  logic signed [WORD_W-1:0] slope_word;
  logic signed [WORD_W-1:0] intercept_word;

  modport source (
    output valid, command, cos_value, entry_index, slope_word, intercept_word,
    input  ready
  );

  modport sink (
    input  valid, command, cos_value, entry_index, slope_word, intercept_word,
    output ready
  );

endinterface

@@ rtl/pla_out_if.sv @@
// ----------------------------------------------------------------------------
// pla_out_if
// Result channel: saturated angle and the segment used.
// ----------------------------------------------------------------------------
interface pla_out_if import pla_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;
  logic [SEG_W-1:0]          segment;

  modport source (
    output valid, angle, segment,
    input  ready
  );

  modport sink (
    input  valid, angle, segment,
    output ready
  );

endinterface

@@ rtl/pla_front.sv @@
// ----------------------------------------------------------------------------
// pla_front
// Magnitude stage and segment search stage of the arccos pipeline.
// ----------------------------------------------------------------------------
module pla_front import pla_pkg::*; #(
  parameter int TABLE_ENTRIES = 21
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv_i,
  pla_in_if.sink     in_ch,
  output logic       b_valid_o,
  output pla_item_t  b_item_o
);

  localparam int SHIFT = 30 - TABLE_ENTRIES;

  logic                     a_valid_r;
  pla_item_t                a_r;
  pla_item_t                a_nxt;
  logic                     b_valid_r;
  pla_item_t                b_r;
  pla_item_t                b_nxt;
  logic [29:0]              rem;
  logic [TABLE_ENTRIES-1:0] v;
  logic [SEG_W-1:0]         msb;

  assign in_ch.ready = adv_i;

  always_comb begin
    a_nxt       = '0;
    a_nxt.cmd   = pla_cmd_t'(in_ch.command);
    a_nxt.neg   = in_ch.cos_value[WORD_W-1];
    a_nxt.mag   = in_ch.cos_value[WORD_W-1] ? WORD_W'(-in_ch.cos_value)
                                             : WORD_W'(in_ch.cos_value);
    a_nxt.wr_ok = int'(in_ch.entry_index) < TABLE_ENTRIES;
    a_nxt.idx   = in_ch.entry_index;
    a_nxt.slope = in_ch.slope_word;
    a_nxt.icpt  = in_ch.intercept_word;
  end

  always_comb begin
    rem = 30'(0) - a_r.mag[29:0];
    v   = rem[29:SHIFT];
    msb = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (v[i]) begin
        msb = SEG_W'(i);
      end
    end
    b_nxt = a_r;
    if (a_r.mag == '0) begin
      b_nxt.seg = '0;
    end else if ((|a_r.mag[31:30]) || (v == '0)) begin
      b_nxt.seg = SEG_W'(TABLE_ENTRIES - 1);
    end else begin
      b_nxt.seg = SEG_W'(TABLE_ENTRIES - 1) - msb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (adv_i) begin
      a_valid_r <= in_ch.valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  assign b_valid_o = b_valid_r;
  assign b_item_o  = b_r;

`ifndef NO_ASSERTIONS
  a_zero_seg: assert property (@(posedge clk) disable iff (!rst_n)
    adv_i && a_valid_r && a_r.cmd == CMD_COMPUTE && a_r.mag == '0
      |=> b_valid_r && b_r.seg == '0)
    else $error("zero magnitude must map to the first segment");

  a_unit_seg: assert property (@(posedge clk) disable iff (!rst_n)
    adv_i && a_valid_r && a_r.cmd == CMD_COMPUTE && (|a_r.mag[31:30])
      |=> b_valid_r && b_r.seg == SEG_W'(TABLE_ENTRIES - 1))
    else $error("magnitude at or above one must map to the last segment");
`endif

endmodule

@@ rtl/pla_coefs.sv @@
// ----------------------------------------------------------------------------
// pla_coefs
// Slope and intercept register file, cleared at reset.
// ----------------------------------------------------------------------------
module pla_coefs import pla_pkg::*; #(
  parameter int ENTRIES = 21
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          we_i,
  input  logic [$clog2(ENTRIES)-1:0]    wr_idx_i,
  input  logic signed [WORD_W-1:0]      wr_slope_i,
  input  logic signed [WORD_W-1:0]      wr_icpt_i,
  input  logic [$clog2(ENTRIES)-1:0]    rd_idx_i,
  output logic signed [WORD_W-1:0]      rd_slope_o,
  output logic signed [WORD_W-1:0]      rd_icpt_o
);

  logic signed [WORD_W-1:0] slope_r [ENTRIES];
  logic signed [WORD_W-1:0] icpt_r  [ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slope_r[i] <= '0;
        icpt_r[i]  <= '0;
      end
    end else if (we_i) begin
      slope_r[wr_idx_i] <= wr_slope_i;
      icpt_r[wr_idx_i]  <= wr_icpt_i;
    end
  end

  assign rd_slope_o = slope_r[rd_idx_i];
  assign rd_icpt_o  = icpt_r[rd_idx_i];

endmodule

@@ rtl/pla_back.sv @@
// ----------------------------------------------------------------------------
// pla_back
// Coefficient, multiply, sum and finish stages with the output register.
// ----------------------------------------------------------------------------
module pla_back import pla_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv_i,
  input  logic                     in_valid_i,
  input  pla_item_t                item_i,
  input  logic signed [WORD_W-1:0] slope_i,
  input  logic signed [WORD_W-1:0] icpt_i,
  pla_out_if.source                out_ch
);

  logic                      c_valid_r;
  logic                      c_neg_r;
  logic [WORD_W-1:0]         c_mag_r;
  logic [SEG_W-1:0]          c_seg_r;
  logic signed [WORD_W-1:0]  c_slope_r;
  logic signed [WORD_W-1:0]  c_icpt_r;

  logic                      d_valid_r;
  logic                      d_neg_r;
  logic [SEG_W-1:0]          d_seg_r;
  logic signed [WORD_W-1:0]  d_icpt_r;
  logic signed [PROD_W-1:0]  d_plo_r;
  logic signed [PROD_W-1:0]  d_phi_r;
  logic signed [PROD_W-1:0]  d_plo_nxt;
  logic signed [PROD_W-1:0]  d_phi_nxt;

  logic                      e_valid_r;
  logic                      e_neg_r;
  logic [SEG_W-1:0]          e_seg_r;
  logic signed [ACC_W-1:0]   e_q_r;
  logic signed [ACC_W-1:0]   e_c_r;
  logic signed [63:0]        prod;
  logic signed [ACC_W-1:0]   e_c_nxt;

  logic                      out_valid_r;
  logic signed [ANGLE_W-1:0] angle_r;
  logic [SEG_W-1:0]          seg_r;
  logic signed [FIN_W-1:0]   ang;
  logic signed [ANGLE_W-1:0] angle_nxt;

  always_comb begin
    d_plo_nxt = $signed({1'b0, c_mag_r[15:0]}) * c_slope_r;
    d_phi_nxt = $signed({1'b0, c_mag_r[31:16]}) * c_slope_r;
  end

  always_comb begin
    prod    = (64'(d_phi_r) <<< 16) + 64'(d_plo_r);
    e_c_nxt = d_neg_r ? PI_Q20 - ACC_W'(d_icpt_r) : ACC_W'(d_icpt_r);
  end

  always_comb begin
    ang = e_neg_r ? FIN_W'(e_c_r) - FIN_W'(e_q_r) : FIN_W'(e_c_r) + FIN_W'(e_q_r);
    if (ang > ANGLE_MAX) begin
      angle_nxt = ANGLE_MAX[ANGLE_W-1:0];
    end else if (ang < ANGLE_MIN) begin
      angle_nxt = ANGLE_MIN[ANGLE_W-1:0];
    end else begin
      angle_nxt = ang[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv_i) begin
      c_valid_r   <= in_valid_i;
      d_valid_r   <= c_valid_r;
      e_valid_r   <= d_valid_r;
      out_valid_r <= e_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      c_neg_r   <= item_i.neg;
      c_mag_r   <= item_i.mag;
      c_seg_r   <= item_i.seg;
      c_slope_r <= slope_i;
      c_icpt_r  <= icpt_i;
      d_neg_r   <= c_neg_r;
      d_seg_r   <= c_seg_r;
      d_icpt_r  <= c_icpt_r;
      d_plo_r   <= d_plo_nxt;
      d_phi_r   <= d_phi_nxt;
      e_neg_r   <= d_neg_r;
      e_seg_r   <= d_seg_r;
      e_q_r     <= prod[63:30];
      e_c_r     <= e_c_nxt;
      angle_r   <= angle_nxt;
      seg_r     <= e_seg_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.angle   = angle_r;
  assign out_ch.segment = seg_r;

endmodule

@@ rtl/piecewise_linear_arccos_unit.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_arccos_unit
// Piecewise linear arccos of a Q1.30 cosine, angle out in Q20 radians.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one word per handshake. A compute word (command 0) brings a
//   cosine and yields one word on out_ch with the saturated angle and the
//   segment used. A write word (command 1) loads slope and intercept of one
//   segment and yields nothing; an index at or past TABLE_ENTRIES is dropped.
//   Writes take effect in word order, so a compute word that follows a write
//   sees the new entry.
//   Throughput: one word per cycle while out_ch is not stalled; six
//   register stages (magnitude, segment search, coefficient fetch, partial
//   products, sum, finish) run in step.
//   Reset: synchronous, active low; empties the pipeline and clears every
//   table entry to zero in the same cycle.
//   Stall: while out_ch holds a word and ready is low, the whole pipeline
//   holds and in_ch.ready goes low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module piecewise_linear_arccos_unit import pla_pkg::*; #(
  parameter int TABLE_ENTRIES = 21
) (
  input  logic      clk,
  input  logic      rst_n,
  pla_in_if.sink    in_ch,
  pla_out_if.source out_ch
);

  localparam int TBL_IDX_W = $clog2(TABLE_ENTRIES);

  logic                     adv;
  logic                     b_valid;
  pla_item_t                b_item;
  logic                     tbl_we;
  logic signed [WORD_W-1:0] rd_slope;
  logic signed [WORD_W-1:0] rd_icpt;

  assign adv    = !out_ch.valid || out_ch.ready;
  assign tbl_we = adv && b_valid && b_item.cmd == CMD_WRITE && b_item.wr_ok;

  pla_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv_i     (adv),
    .in_ch     (in_ch),
    .b_valid_o (b_valid),
    .b_item_o  (b_item)
  );

  pla_coefs #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_coefs (
    .clk        (clk),
    .rst_n      (rst_n),
    .we_i       (tbl_we),
    .wr_idx_i   (b_item.idx[TBL_IDX_W-1:0]),
    .wr_slope_i (b_item.slope),
    .wr_icpt_i  (b_item.icpt),
    .rd_idx_i   (b_item.seg[TBL_IDX_W-1:0]),
    .rd_slope_o (rd_slope),
    .rd_icpt_o  (rd_icpt)
  );

  pla_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv_i      (adv),
    .in_valid_i (b_valid && b_item.cmd == CMD_COMPUTE),
    .item_i     (b_item),
    .slope_i    (rd_slope),
    .icpt_i     (rd_icpt),
    .out_ch     (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> int'(out_ch.segment) < TABLE_ENTRIES)
    else $error("result segment outside the table");

  a_we_range: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> int'(b_item.idx) < TABLE_ENTRIES && !$isunknown(b_item.idx))
    else $error("table write outside the table");
`endif

endmodule
